@@ sv/rpwc_pkg.sv @@
// Package for the relay pulse watchdog controller: request and response
// payload types, request, status, policy and register codes, reset values.
// No dependencies.
package rpwc_pkg;

	localparam int CHANNELS = 6;
	localparam int CFG_BITS = 24;

	typedef enum logic [2:0] {
		REQ_SET_ONE = 3'd0,
		REQ_SET_ALL = 3'd1,
		REQ_PULSE   = 3'd2,
		REQ_RENEW   = 3'd3,
		REQ_TICK    = 3'd4,
		REQ_RESTART = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_BAD_ARG = 2'd1,
		STATUS_BUSY    = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		POLICY_NONE      = 2'd0,
		POLICY_ENERGIZED = 2'd1,
		POLICY_OWNER     = 2'd2
	} policy_code_t;

	typedef enum logic [2:0] {
		CFG_COMM_POLICY     = 3'd0,
		CFG_REBOOT_ON_TMO   = 3'd1,
		CFG_COMM_TIMEOUT    = 3'd2,
		CFG_REBOOT_DELAY    = 3'd3,
		CFG_PENDING_LEAD    = 3'd4,
		CFG_PULSE_MIN       = 3'd5,
		CFG_PULSE_MAX       = 3'd6
	} cfg_code_t;

	localparam logic [1:0]          RST_COMM_POLICY   = POLICY_ENERGIZED;
	localparam logic [CFG_BITS-1:0] RST_COMM_TIMEOUT  = 24'd5000;
	localparam logic [CFG_BITS-1:0] RST_REBOOT_DELAY  = 24'd5000;
	localparam logic [CFG_BITS-1:0] RST_PENDING_LEAD  = 24'd10000;
	localparam logic [CFG_BITS-1:0] RST_PULSE_MIN     = 24'd1;
	localparam logic [CFG_BITS-1:0] RST_PULSE_MAX     = 24'd60000;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  channel;
		logic        turn_on;
		logic [7:0]  all_mask;
		logic [23:0] pulse_ms;
	} rpwc_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] relay_levels;
		logic [5:0] pulsing_mask;
		logic       owner_timed_out;
		logic       reboot_pending;
		logic       reboot_request;
		logic       watchdog_armed;
	} rpwc_rsp_t;

endpackage

@@ sv/relay_pulse_watchdog_controller_core.sv @@
// Top level of the relay pulse watchdog controller: input register, request
// decode with per-channel pulse counters and watchdog, response register.
// Depends on rpwc_pkg.
//
// Usage: requests arrive on the req channel (req_valid, req_stall, req) and
// each one produces exactly one response on the rsp channel (rsp_valid,
// rsp_stall, rsp). A transfer happens at a rising edge where valid is high
// and stall is low. Requests are set one relay, set all relays, timed pulse,
// renew (watchdog kick), 1 ms tick and restart.
// A request that is taken goes into the input register, is evaluated from
// there, and its response is registered in the response register, which
// raises rsp_valid. Throughput is one request per cycle while the receiver
// does not stall; all six pulse counters and the watchdog, reboot and
// indication countdowns update in parallel in that single evaluation step.
// When the receiver stalls, the held response stays put and the request in
// the input register waits; req_stall rises only while both are occupied.
// Asynchronous reset (arst_n low) clears relays, pulses, all countdowns and
// flags, and loads the configuration registers with their defaults.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata, one
// register per cycle, and is meant to be written while the block is idle.
module relay_pulse_watchdog_controller_core
	import rpwc_pkg::*;
#(
	parameter int TIME_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rpwc_req_t     req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rpwc_rsp_t     rsp,
	input  logic          cfg_wr_en,
	input  logic [2:0]    cfg_index,
	input  logic [CFG_BITS-1:0] cfg_wdata
);

	typedef logic [TIME_BITS-1:0] tcount_t;

	// Configuration registers.
	logic [1:0]          policy_q;
	logic                reboot_on_tmo_q;
	logic [CFG_BITS-1:0] comm_timeout_q;
	logic [CFG_BITS-1:0] reboot_delay_q;
	logic [CFG_BITS-1:0] pending_lead_q;
	logic [CFG_BITS-1:0] pulse_min_q;
	logic [CFG_BITS-1:0] pulse_max_q;

	// Input stage and response register.
	rpwc_req_t req_s1;
	logic      valid_s1;
	rpwc_rsp_t rsp_q;
	logic      rsp_valid_q;
	logic      advance;

	// Controller state.
	logic [CHANNELS-1:0] relay_q, pmask_q;
	tcount_t             pleft_q [CHANNELS];
	logic                armed_q, rb_armed_q, ind_armed_q, tout_q, pend_q;
	tcount_t             watch_q, rb_left_q, ind_left_q;

	// Next-state values from the evaluation step.
	logic [CHANNELS-1:0] relay_n, pmask_n, expired_c;
	tcount_t             pleft_n [CHANNELS];
	logic                armed_n, rb_armed_n, ind_armed_n, tout_n, pend_n;
	tcount_t             watch_n, rb_left_n, ind_left_n;
	logic [1:0]          status_c;
	logic                reboot_req_c, tail_c;
	tcount_t             timeout_t, delay_t;

	function automatic logic arm_watch(input logic [1:0] pol,
			input logic [CHANNELS-1:0] relays, input logic [CHANNELS-1:0] pulses);
		logic arm;
		arm = 1'b0;
		if (pol == POLICY_OWNER) begin
			arm = 1'b1;
		end else if (pol == POLICY_ENERGIZED) begin
			arm = (relays != '0) || (pulses != '0);
		end
		return arm;
	endfunction

	assign timeout_t = TIME_BITS'(comm_timeout_q);
	assign delay_t   = TIME_BITS'(reboot_delay_q);

	// The input register frees up whenever the response register can take
	// a new response, so back-to-back requests flow without a bubble.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q        <= RST_COMM_POLICY;
			reboot_on_tmo_q <= 1'b0;
			comm_timeout_q  <= RST_COMM_TIMEOUT;
			reboot_delay_q  <= RST_REBOOT_DELAY;
			pending_lead_q  <= RST_PENDING_LEAD;
			pulse_min_q     <= RST_PULSE_MIN;
			pulse_max_q     <= RST_PULSE_MAX;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_COMM_POLICY:   policy_q        <= cfg_wdata[1:0];
				CFG_REBOOT_ON_TMO: reboot_on_tmo_q <= cfg_wdata[0];
				CFG_COMM_TIMEOUT:  comm_timeout_q  <= cfg_wdata;
				CFG_REBOOT_DELAY:  reboot_delay_q  <= cfg_wdata;
				CFG_PENDING_LEAD:  pending_lead_q  <= cfg_wdata;
				CFG_PULSE_MIN:     pulse_min_q     <= cfg_wdata;
				CFG_PULSE_MAX:     pulse_max_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Evaluation of one request against the current state. The order inside
	// a tick matters: pulse expiry first, then the indication and reboot
	// countdowns, then the communication watchdog.
	always_comb begin
		relay_n      = relay_q;
		pmask_n      = pmask_q;
		pleft_n      = pleft_q;
		armed_n      = armed_q;
		watch_n      = watch_q;
		rb_armed_n   = rb_armed_q;
		rb_left_n    = rb_left_q;
		ind_armed_n  = ind_armed_q;
		ind_left_n   = ind_left_q;
		tout_n       = tout_q;
		pend_n       = pend_q;
		status_c     = STATUS_OK;
		reboot_req_c = 1'b0;
		tail_c       = 1'b0;
		expired_c    = '0;

		case (req_s1.req_type)
			REQ_SET_ONE: begin
				if (4'(req_s1.channel) >= 4'(CHANNELS)) begin
					status_c = STATUS_BAD_ARG;
				end else begin
					for (int i = 0; i < CHANNELS; i++) begin
						if (req_s1.channel == 3'(i)) begin
							pleft_n[i] = '0;
							pmask_n[i] = 1'b0;
							relay_n[i] = req_s1.turn_on;
						end
					end
					tail_c = 1'b1;
				end
			end
			REQ_SET_ALL: begin
				if (req_s1.all_mask[7:CHANNELS] != '0) begin
					status_c = STATUS_BAD_ARG;
				end else begin
					for (int i = 0; i < CHANNELS; i++) begin
						pleft_n[i] = '0;
					end
					pmask_n = '0;
					relay_n = req_s1.all_mask[CHANNELS-1:0];
					tail_c  = 1'b1;
				end
			end
			REQ_PULSE: begin
				if (4'(req_s1.channel) >= 4'(CHANNELS) ||
						req_s1.pulse_ms < pulse_min_q ||
						req_s1.pulse_ms > pulse_max_q) begin
					status_c = STATUS_BAD_ARG;
				end else if (pmask_q[req_s1.channel]) begin
					status_c = STATUS_BUSY;
				end else begin
					for (int i = 0; i < CHANNELS; i++) begin
						if (req_s1.channel == 3'(i)) begin
							relay_n[i] = 1'b1;
							pmask_n[i] = 1'b1;
							pleft_n[i] = TIME_BITS'(req_s1.pulse_ms);
						end
					end
					tail_c = 1'b1;
				end
			end
			REQ_RENEW: begin
				tail_c = 1'b1;
			end
			REQ_TICK: begin
				// Pulse counters: a count of zero or one expires now.
				for (int i = 0; i < CHANNELS; i++) begin
					if (pmask_q[i]) begin
						if (pleft_q[i] <= TIME_BITS'(1)) begin
							pleft_n[i]   = '0;
							expired_c[i] = 1'b1;
						end else begin
							pleft_n[i] = pleft_q[i] - TIME_BITS'(1);
						end
					end
				end
				if (expired_c != '0) begin
					pmask_n = pmask_n & ~expired_c;
					relay_n = relay_n & ~expired_c;
					if (policy_q == POLICY_ENERGIZED && relay_n == '0 && pmask_n == '0) begin
						armed_n = 1'b0;
						watch_n = '0;
					end
				end

				// Pending indication and reboot countdowns.
				if (rb_armed_q && ind_armed_q && ind_left_q != '0) begin
					ind_left_n = ind_left_q - TIME_BITS'(1);
					if (ind_left_n == '0) begin
						ind_armed_n = 1'b0;
						pend_n      = 1'b1;
					end
				end
				if (rb_armed_q && rb_left_q != '0) begin
					rb_left_n = rb_left_q - TIME_BITS'(1);
					if (rb_left_n == '0) begin
						reboot_req_c = 1'b1;
					end
				end

				// Communication watchdog.
				if (armed_n) begin
					if (watch_n <= TIME_BITS'(1)) begin
						watch_n = '0;
						for (int i = 0; i < CHANNELS; i++) begin
							pleft_n[i] = '0;
						end
						pmask_n = '0;
						relay_n = '0;
						tout_n  = 1'b1;
						if (policy_q == POLICY_OWNER) begin
							if (reboot_on_tmo_q) begin
								armed_n    = 1'b0;
								rb_armed_n = 1'b1;
								rb_left_n  = delay_t;
								if (delay_t == '0) begin
									reboot_req_c = 1'b1;
								end
								if (32'(delay_t) <= 32'(pending_lead_q)) begin
									ind_armed_n = 1'b0;
									ind_left_n  = '0;
									pend_n      = 1'b1;
								end else begin
									ind_armed_n = 1'b1;
									ind_left_n  = TIME_BITS'(32'(delay_t) - 32'(pending_lead_q));
								end
							end else begin
								// Always-on owner without reboot just re-arms.
								armed_n = 1'b1;
								watch_n = timeout_t;
							end
						end else begin
							armed_n = 1'b0;
						end
					end else begin
						watch_n = watch_n - TIME_BITS'(1);
					end
				end
			end
			REQ_RESTART: begin
				relay_n = '0;
				pmask_n = '0;
				for (int i = 0; i < CHANNELS; i++) begin
					pleft_n[i] = '0;
				end
				rb_armed_n  = 1'b0;
				rb_left_n   = '0;
				ind_armed_n = 1'b0;
				ind_left_n  = '0;
				tout_n      = 1'b0;
				pend_n      = 1'b0;
				armed_n     = (policy_q == POLICY_OWNER);
				watch_n     = (policy_q == POLICY_OWNER) ? timeout_t : '0;
			end
			default: begin
				status_c = STATUS_BAD_ARG;
			end
		endcase

		// Shared tail of every accepted set or pulse command and of renew: cancel any
		// reboot in progress and restart the watchdog under the policy.
		if (tail_c) begin
			if (rb_armed_q) begin
				pend_n = 1'b0;
			end
			rb_armed_n  = 1'b0;
			rb_left_n   = '0;
			ind_armed_n = 1'b0;
			ind_left_n  = '0;
			tout_n      = 1'b0;
			armed_n     = arm_watch(policy_q, relay_n, pmask_n);
			watch_n     = armed_n ? timeout_t : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			relay_q     <= '0;
			pmask_q     <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pleft_q[i] <= '0;
			end
			armed_q     <= 1'b0;
			watch_q     <= '0;
			rb_armed_q  <= 1'b0;
			rb_left_q   <= '0;
			ind_armed_q <= 1'b0;
			ind_left_q  <= '0;
			tout_q      <= 1'b0;
			pend_q      <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				relay_q     <= relay_n;
				pmask_q     <= pmask_n;
				pleft_q     <= pleft_n;
				armed_q     <= armed_n;
				watch_q     <= watch_n;
				rb_armed_q  <= rb_armed_n;
				rb_left_q   <= rb_left_n;
				ind_armed_q <= ind_armed_n;
				ind_left_q  <= ind_left_n;
				tout_q      <= tout_n;
				pend_q      <= pend_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.status          <= status_c;
			rsp_q.relay_levels    <= 6'(relay_n);
			rsp_q.pulsing_mask    <= 6'(pmask_n);
			rsp_q.owner_timed_out <= tout_n;
			rsp_q.reboot_pending  <= pend_n;
			rsp_q.reboot_request  <= reboot_req_c;
			rsp_q.watchdog_armed  <= armed_n;
		end
	end

endmodule

@@ sv/rpwc_checker.sv @@
// Port-level checker for the relay pulse watchdog controller, bound to the
// top level. Depends on rpwc_pkg and relay_pulse_watchdog_controller_core.
module rpwc_port_checker
	import rpwc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rpwc_rsp_t rsp
);

	// A stalled response must hold until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A channel with a running pulse always has its relay energized.
	a_pulse_on: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pulsing_mask & ~rsp.relay_levels) == 6'd0)
		else $error("pulsing channel with relay off");

	// A reboot request only follows a timeout that dropped every relay.
	a_reboot_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reboot_request |->
			rsp.owner_timed_out && rsp.relay_levels == 6'd0)
		else $error("reboot request without timeout");

	// The pending indication is up no later than the reboot request.
	a_reboot_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reboot_request |-> rsp.reboot_pending)
		else $error("reboot request without pending indication");

endmodule

bind relay_pulse_watchdog_controller_core rpwc_port_checker u_rpwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
